// ===== hw/rtl/sierpinski_carpet_pixel_assert.svh =====
// Assertion macros for the Sierpinski carpet pixel block.
`ifndef SIERPINSKI_CARPET_PIXEL_ASSERT_SVH
`define SIERPINSKI_CARPET_PIXEL_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SCP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scp assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SCP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scp assertion failed");

`endif

// ===== hw/rtl/scp_pkg.sv =====
// Shared types, constants and helpers for the Sierpinski carpet pixel block.
`timescale 1ns / 1ps
`default_nettype none
package scp_pkg;

    localparam int COORD_W   = 12;
    localparam int SIDE_W    = 13;
    localparam int LEVELS_W  = 4;
    localparam int COLOR_W   = 24;
    localparam int CHAN_W    = 8;
    localparam int CFG_IDX_W = 8;

    localparam int DEF_MAX_LEVELS = 8;
    localparam int DEF_MAX_SIDE   = 4096;

    localparam logic [SIDE_W-1:0]  SIDE_RST  = SIDE_W'(729);
    localparam logic [COLOR_W-1:0] BASE_RST  = COLOR_W'(24'hFFFFFF);
    localparam logic [COLOR_W-1:0] HOLE_RST  = COLOR_W'(0);

    // floor(s / 3) as (s * ceil(2^(SIDE_W+1) / 3)) >> (SIDE_W+1), exact for s < 2^SIDE_W
    localparam int                DIV3_SHIFT = SIDE_W + 1;
    localparam logic [SIDE_W-1:0] DIV3_MUL   = SIDE_W'(((1 << DIV3_SHIFT) + 2) / 3);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIDE_LENGTH = 8'd0,
        REG_LEVELS      = 8'd1,
        REG_BASE_COLOR  = 8'd2,
        REG_HOLE_COLOR  = 8'd3
    } cfg_reg_e;

    typedef struct packed {
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [COORD_W-1:0] n;
        logic               done;
        logic               hole;
        logic               outside;
    } scp_pix_t;

    function automatic logic [COORD_W-1:0] div3(input logic [SIDE_W-1:0] s);
        logic [2*SIDE_W-1:0] prod;
        prod = (2*SIDE_W)'(s) * (2*SIDE_W)'(DIV3_MUL);
        return prod[DIV3_SHIFT +: COORD_W];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/scp_front.sv =====
// Entry stage: side clamp, range check and first cell side.
`timescale 1ns / 1ps
`default_nettype none
module scp_front #(
    parameter int MAX_SIDE = scp_pkg::DEF_MAX_SIDE
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [scp_pkg::SIDE_W-1:0] side_length,
    input  wire logic                       in_valid,
    output      logic                       in_ready,
    input  wire logic [scp_pkg::COORD_W-1:0] pixel_x,
    input  wire logic [scp_pkg::COORD_W-1:0] pixel_y,
    output      logic                       out_valid,
    input  wire logic                       out_ready,
    output      scp_pkg::scp_pix_t          out_pix
);
    import scp_pkg::*;

    logic              valid_reg;
    scp_pix_t          pix_reg;
    scp_pix_t          pix_next;
    logic [SIDE_W-1:0] side;

    always_comb
    begin
        if (32'(side_length) > MAX_SIDE)
            side = SIDE_W'(MAX_SIDE);
        else
            side = side_length;
        pix_next.dx      = pixel_x;
        pix_next.dy      = pixel_y;
        pix_next.n       = div3(side);
        pix_next.outside = ({1'b0, pixel_x} >= side) || ({1'b0, pixel_y} >= side);
        pix_next.done    = pix_next.outside;
        pix_next.hole    = 1'b0;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            pix_reg <= pix_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/scp_cell.sv =====
// One subdivision level of the carpet: hole test, descent and next cell side.
`timescale 1ns / 1ps
`default_nettype none
module scp_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              active,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire scp_pkg::scp_pix_t in_pix,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      scp_pkg::scp_pix_t out_pix
);
    import scp_pkg::*;

    logic               valid_reg;
    scp_pix_t           pix_reg;
    scp_pix_t           pix_next;
    logic [COORD_W:0]   n2;
    logic [COORD_W+1:0] n3;
    logic               mid_x;
    logic               mid_y;
    logic               beyond;
    logic [COORD_W-1:0] off_x;
    logic [COORD_W-1:0] off_y;

    always_comb
    begin
        n2     = {in_pix.n, 1'b0};
        n3     = {1'b0, n2} + {2'b00, in_pix.n};
        mid_x  = (in_pix.dx >= in_pix.n) && ({1'b0, in_pix.dx} < n2);
        mid_y  = (in_pix.dy >= in_pix.n) && ({1'b0, in_pix.dy} < n2);
        beyond = ({2'b00, in_pix.dx} >= n3) || ({2'b00, in_pix.dy} >= n3);
        // offset of the cell; only used when the coordinate lies below 3n
        if (in_pix.dx < in_pix.n)
            off_x = '0;
        else if ({1'b0, in_pix.dx} < n2)
            off_x = in_pix.n;
        else
            off_x = n2[COORD_W-1:0];
        if (in_pix.dy < in_pix.n)
            off_y = '0;
        else if ({1'b0, in_pix.dy} < n2)
            off_y = in_pix.n;
        else
            off_y = n2[COORD_W-1:0];

        pix_next   = in_pix;
        pix_next.n = div3({1'b0, in_pix.n});
        if (active && !in_pix.done)
        begin
            if (in_pix.n == '0)
                pix_next.done = 1'b1;
            else if (mid_x && mid_y)
            begin
                pix_next.done = 1'b1;
                pix_next.hole = 1'b1;
            end
            else if (beyond)
                pix_next.done = 1'b1;
            else
            begin
                pix_next.dx = in_pix.dx - off_x;
                pix_next.dy = in_pix.dy - off_y;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            pix_reg <= pix_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/sierpinski_carpet_pixel.sv =====
// Sierpinski carpet pixel colour generator, top level.
// Takes one pixel coordinate per clock while in_stall is low and returns its
// carpet colour: an entry stage checks the coordinate against the side
// length and forms the first cell side, then a chain of MAX_LEVELS cells,
// one per subdivision level, each test and descend one level and hand the
// next cell side on. Every stage holds its own transfer, so bubbles close up
// and a stalled result does not stop the chain until it is full. Configuration
// registers are to be written through cfg_valid/cfg_ready only while the block
// is idle; the block itself does not enforce this. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module sierpinski_carpet_pixel #(
    parameter int MAX_LEVELS = scp_pkg::DEF_MAX_LEVELS,
    parameter int MAX_SIDE   = scp_pkg::DEF_MAX_SIDE
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [scp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [scp_pkg::COLOR_W-1:0]   cfg_data,
    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire logic [scp_pkg::COORD_W-1:0]   pixel_x,
    input  wire logic [scp_pkg::COORD_W-1:0]   pixel_y,
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      logic [scp_pkg::CHAN_W-1:0]    red,
    output      logic [scp_pkg::CHAN_W-1:0]    green,
    output      logic [scp_pkg::CHAN_W-1:0]    blue,
    output      logic                          removed,
    output      logic                          outside
);
    import scp_pkg::*;

    logic [SIDE_W-1:0]   side_length_reg;
    logic [LEVELS_W-1:0] levels_reg;
    logic [COLOR_W-1:0]  base_color_reg;
    logic [COLOR_W-1:0]  hole_color_reg;

    scp_pix_t            stage_pix   [MAX_LEVELS+1];
    logic [MAX_LEVELS:0] stage_valid;
    logic [MAX_LEVELS:0] stage_ready;
    logic                front_ready;
    logic [MAX_LEVELS-1:0] cell_active;
    logic [COLOR_W-1:0]  color;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_length_reg <= SIDE_RST;
            levels_reg      <= '0;
            base_color_reg  <= BASE_RST;
            hole_color_reg  <= HOLE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SIDE_LENGTH: side_length_reg <= cfg_data[SIDE_W-1:0];
                REG_LEVELS:      levels_reg      <= cfg_data[LEVELS_W-1:0];
                REG_BASE_COLOR:  base_color_reg  <= cfg_data;
                REG_HOLE_COLOR:  hole_color_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    scp_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .side_length (side_length_reg),
        .in_valid    (in_valid),
        .in_ready    (front_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .out_valid   (stage_valid[0]),
        .out_ready   (stage_ready[0]),
        .out_pix     (stage_pix[0])
    );

    assign in_stall = !front_ready;

    // levels beyond the chain length fall away on their own
    for (genvar k = 0; k < MAX_LEVELS; k++)
    begin : g_cell
        assign cell_active[k] = (32'(levels_reg) > k);

        scp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .active    (cell_active[k]),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_pix    (stage_pix[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_pix   (stage_pix[k+1])
        );
    end

    assign stage_ready[MAX_LEVELS] = !out_stall;

    assign color     = stage_pix[MAX_LEVELS].hole ? hole_color_reg : base_color_reg;
    assign out_valid = stage_valid[MAX_LEVELS];
    assign red       = color[3*CHAN_W-1:2*CHAN_W];
    assign green     = color[2*CHAN_W-1:CHAN_W];
    assign blue      = color[CHAN_W-1:0];
    assign removed   = stage_pix[MAX_LEVELS].hole;
    assign outside   = stage_pix[MAX_LEVELS].outside;

endmodule
`default_nettype wire

// ===== hw/rtl/scp_checker.sv =====
// Port-level checks for the Sierpinski carpet pixel block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "sierpinski_carpet_pixel_assert.svh"
module scp_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [scp_pkg::CHAN_W-1:0]    red,
    input wire logic [scp_pkg::CHAN_W-1:0]    green,
    input wire logic [scp_pkg::CHAN_W-1:0]    blue,
    input wire logic                          removed,
    input wire logic                          outside
);
    // input may only back up when a result is held at the output
    `SCP_ASSERT_IMPL(a_stall_only_when_full, in_stall, out_valid && out_stall)
    // a removed pixel always lies inside the image
    `SCP_ASSERT_IMPL(a_removed_inside, out_valid, !(removed && outside))
    `SCP_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid)
    `SCP_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
        $stable(red) && $stable(green) && $stable(blue) && $stable(removed) && $stable(outside))
endmodule

bind sierpinski_carpet_pixel scp_checker u_scp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .removed   (removed),
    .outside   (outside)
);
`default_nettype wire
